// ----- hw/rtl/lrufr_pkg.sv -----
// Shared types and sizes for the LRU frame replacement block.
// No dependencies; imported by lrufr_store and lru_frame_replacement.
package lrufr_pkg;

  localparam int unsigned FRAMES     = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned PAGE_BITS  = 16;
  localparam int unsigned STAMP_BITS = 32;
  localparam int unsigned FAULT_W    = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [FAULT_W-1:0]    fault_t;

  // Write-back request into the frame store.
  typedef struct packed {
    logic   en;       // write the stamp of frame idx
    logic   page_en;  // also load a new page and mark the frame valid
    idx_t   idx;
    page_t  page;
    stamp_t stamp;
  } wr_req_t;

endpackage

// ----- hw/rtl/lrufr_store.sv -----
// Frame store: page and stamp memories with registered reads,
// plus the per-frame valid bits. Depends on lrufr_pkg.
module lrufr_store import lrufr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  idx_t              rd_idx_i,
  output page_t             rd_page_o,
  output stamp_t            rd_stamp_o,
  output logic [FRAMES-1:0] valid_o,
  input  wr_req_t           wr_i
);

  page_t             page_mem  [FRAMES];
  stamp_t            stamp_mem [FRAMES];
  page_t             rd_page_q;
  stamp_t            rd_stamp_q;
  logic [FRAMES-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.page_en) begin
      page_mem[wr_i.idx] <= wr_i.page;
    end
    rd_page_q <= page_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      stamp_mem[wr_i.idx] <= wr_i.stamp;
    end
    rd_stamp_q <= stamp_mem[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en && wr_i.page_en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  assign rd_page_o  = rd_page_q;
  assign rd_stamp_o = rd_stamp_q;
  assign valid_o    = valid_q;

endmodule

// ----- hw/rtl/lru_frame_replacement.sv -----
// Top level of the LRU frame replacement block: request sequencer,
// counters and result register. Depends on lrufr_pkg and lrufr_store.
//
// Usage:
//   A request carries one page number on in_valid_i / page_number_i and is
//   taken at a clock edge where in_valid_i is high and in_stall_o is low.
//   Each request yields exactly one result on out_valid_o with hit_o,
//   frame_index_o, evicted_valid_o, evicted_page_o and fault_count_o; the
//   receiver holds it with out_stall_i.
//   The sequencer walks frames 0 .. n-1 (n = frames_in_use clamped to
//   1..8) through the page/stamp memories, one frame per cycle, finding the
//   first matching frame and the oldest stamp in one pass; the first empty
//   frame comes from the valid bits. A drain state covers the memory read
//   latency, a write state writes back, and a done state hands the result
//   to the output register. A new request is taken only once the sequencer
//   is back in idle, after the previous result has entered the output
//   register.
//   The output register frees the input side: a new request is taken while
//   a stalled result still waits; its own result then holds in the
//   sequencer until the output register empties.
//   Reset clears the valid bits, counters and the output valid, and loads
//   frames_in_use with 8. Write cfg_wdata_i via cfg_we_i only while idle.
module lru_frame_replacement import lrufr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  page_t            page_number_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             hit_o,
  output idx_t             frame_index_o,
  output logic             evicted_valid_o,
  output page_t            evicted_page_o,
  output fault_t           fault_count_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  cfg_q;
  logic [CFG_W-1:0]  n_act;
  idx_t              last_idx;
  idx_t              last_q;
  idx_t              scan_idx_q;
  page_t             page_q;
  stamp_t            ref_cnt_q;
  fault_t            fault_total_q;

  // Scan results
  logic              cmp_en_q;
  idx_t              cmp_idx_q;
  logic              found_q;
  idx_t              hit_idx_q;
  stamp_t            min_stamp_q;
  idx_t              min_idx_q;
  page_t             min_page_q;

  // Pending result, held until the output register is free
  logic              res_hit_q;
  idx_t              res_idx_q;
  logic              res_ev_valid_q;
  page_t             res_ev_page_q;
  fault_t            res_fault_q;

  // Output register
  logic              out_valid_q;
  logic              hit_q;
  idx_t              frame_index_q;
  logic              evicted_valid_q;
  page_t             evicted_page_q;
  fault_t            fault_count_q;

  page_t             rd_page;
  stamp_t            rd_stamp;
  logic [FRAMES-1:0] valid_vec;
  wr_req_t           wr_req;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              empty_found;
  idx_t              empty_idx;
  idx_t              slot;
  logic              match;

  lrufr_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (scan_idx_q),
    .rd_page_o  (rd_page),
    .rd_stamp_o (rd_stamp),
    .valid_o    (valid_vec),
    .wr_i       (wr_req)
  );

  // Clamp the frame count to 1..FRAMES.
  always_comb begin
    n_act = cfg_q;
    if (cfg_q == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg_q > CFG_W'(FRAMES)) begin
      n_act = CFG_W'(FRAMES);
    end
    last_idx = IDX_W'(n_act - CFG_W'(1));
  end

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == ST_DONE) && out_free;
  assign match    = valid_vec[cmp_idx_q] && (rd_page == page_q);

  // Lowest empty frame among those in use.
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (IDX_W'(i) <= last_q && !valid_vec[i]) begin
        empty_found = 1'b1;
        empty_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (found_q) begin
      slot = hit_idx_q;
    end else if (empty_found) begin
      slot = empty_idx;
    end else begin
      slot = min_idx_q;
    end
  end

  always_comb begin
    wr_req         = '0;
    wr_req.en      = (state_q == ST_WRITE);
    wr_req.page_en = (state_q == ST_WRITE) && !found_q;
    wr_req.idx     = slot;
    wr_req.page    = page_q;
    wr_req.stamp   = ref_cnt_q;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN:  if (scan_idx_q == last_q) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cfg_q         <= CFG_RESET;
      ref_cnt_q     <= '0;
      fault_total_q <= '0;
      scan_idx_q    <= '0;
      cmp_en_q      <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmp_en_q <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      // Start the walk at frame 0 and bump the saturating reference count.
      if (accept) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        if (ref_cnt_q != '1) begin
          ref_cnt_q <= ref_cnt_q + STAMP_BITS'(1);
        end
      end else if (state_q == ST_SCAN && scan_idx_q != last_q) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (cmp_en_q && match && !found_q) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_WRITE && !found_q && fault_total_q != '1) begin
        fault_total_q <= fault_total_q + FAULT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      page_q <= page_number_i;
      last_q <= last_idx;
    end
    cmp_idx_q <= scan_idx_q;
    if (cmp_en_q) begin
      // Keep the first match; keep the oldest stamp, lowest index on a tie.
      if (match && !found_q) begin
        hit_idx_q <= cmp_idx_q;
      end
      if (cmp_idx_q == '0 || rd_stamp < min_stamp_q) begin
        min_stamp_q <= rd_stamp;
        min_idx_q   <= cmp_idx_q;
        min_page_q  <= rd_page;
      end
    end
    if (state_q == ST_WRITE) begin
      res_hit_q      <= found_q;
      res_idx_q      <= slot;
      res_ev_valid_q <= !found_q && !empty_found;
      res_ev_page_q  <= (!found_q && !empty_found) ? min_page_q : '0;
      res_fault_q    <= (!found_q && fault_total_q != '1) ?
                        fault_total_q + FAULT_W'(1) : fault_total_q;
    end
    if (load_out) begin
      hit_q           <= res_hit_q;
      frame_index_q   <= res_idx_q;
      evicted_valid_q <= res_ev_valid_q;
      evicted_page_q  <= res_ev_page_q;
      fault_count_q   <= res_fault_q;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = frame_index_q;
  assign evicted_valid_o = evicted_valid_q;
  assign evicted_page_o  = evicted_page_q;
  assign fault_count_o   = fault_count_q;

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> !evicted_valid_o && evicted_page_o == '0)
    else $error("hit reported with an evicted page");

  // The fault total never goes backward.
  a_fault_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |=> fault_total_q >= $past(fault_total_q))
    else $error("fault total decreased");

  // A write-back leaves the chosen frame valid.
  a_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |=> valid_vec[$past(slot)])
    else $error("written frame not valid");

  // No compare is in flight while a new request may be taken.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !cmp_en_q)
    else $error("compare in flight while idle");

endmodule

// ----- bench/tb.sv -----
// Testbench for lru_frame_replacement: drives page requests under random
// idling and back-pressure and checks every result against a frame table model.
// Depends on lrufr_pkg and the lru_frame_replacement RTL.
`timescale 1ns / 1ps

module tb;
  import lrufr_pkg::*;

  // Sizing of the run.
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 185;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam longint unsigned TIMEOUT_NS  = 64'd10_000_000;

  // Table sizes swept by the random phases; the rest are drawn at random.
  localparam int unsigned SWEEP [8] = '{1, 8, 0, 15, 3, 12, 2, 6};

  // One result of the block, field for field.
  typedef struct packed {
    logic   hit;
    idx_t   frame;
    logic   evicted_valid;
    page_t  evicted_page;
    fault_t faults;
  } outcome_t;

  // Frame table model: mirrors the LRU table, predicts one outcome per
  // accepted request and compares the results in order.
  class frame_table_model;
    page_t              pages  [FRAMES];
    bit                 valid  [FRAMES];
    stamp_t             stamps [FRAMES];
    stamp_t             ref_count;
    fault_t             faults;
    logic [CFG_W-1:0]   frames_in_use;
    outcome_t           pending_outcomes [$];
    int unsigned        errors;
    int unsigned        hits;
    int unsigned        misses;

    function new();
      foreach (valid[i]) begin
        pages[i]  = '0;
        valid[i]  = 1'b0;
        stamps[i] = '0;
      end
      ref_count     = '0;
      faults        = '0;
      frames_in_use = CFG_RESET;
      errors        = 0;
      hits          = 0;
      misses        = 0;
    endfunction

    function void set_frames(logic [CFG_W-1:0] value);
      frames_in_use = value;
    endfunction

    function int unsigned outstanding();
      return pending_outcomes.size();
    endfunction

    // Predict the outcome of one accepted request and queue it.
    function void note_request(page_t page);
      int unsigned n;
      int unsigned slot;
      bit          found;
      bit          empty;
      outcome_t    o;
      n = frames_in_use;
      if (n < 1) n = 1;
      if (n > FRAMES) n = FRAMES;
      if (ref_count != '1) ref_count++;
      found = 1'b0;
      slot  = 0;
      o     = '0;
      // lowest matching frame wins, which also settles duplicate residency
      for (int unsigned i = 0; i < n; i++)
        if (!found && valid[i] && pages[i] == page) begin
          found = 1'b1;
          slot  = i;
        end
      if (found) begin
        stamps[slot] = ref_count;
      end else begin
        empty = 1'b0;
        for (int unsigned i = 0; i < n; i++)
          if (!empty && !valid[i]) begin
            empty = 1'b1;
            slot  = i;
          end
        if (!empty) begin
          // oldest stamp goes, ties to the lowest frame
          slot = 0;
          for (int unsigned i = 1; i < n; i++)
            if (stamps[i] < stamps[slot]) slot = i;
          o.evicted_valid = 1'b1;
          o.evicted_page  = pages[slot];
        end
        pages[slot]  = page;
        valid[slot]  = 1'b1;
        stamps[slot] = ref_count;
        if (faults != '1) faults++;
      end
      o.hit    = found;
      o.frame  = idx_t'(slot);
      o.faults = faults;
      pending_outcomes.push_back(o);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(outcome_t got);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding: hit=%0d frame=%0d", got.hit, got.frame);
        errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      if (want.hit) hits++;
      else misses++;
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit);
        errors++;
      end
      if (got.frame !== want.frame) begin
        $error("frame_index: expected %0d, got %0d", want.frame, got.frame);
        errors++;
      end
      if (got.evicted_valid !== want.evicted_valid) begin
        $error("evicted_valid: expected %0d, got %0d", want.evicted_valid, got.evicted_valid);
        errors++;
      end
      if (got.evicted_page !== want.evicted_page) begin
        $error("evicted_page: expected %h, got %h", want.evicted_page, got.evicted_page);
        errors++;
      end
      if (got.faults !== want.faults) begin
        $error("fault_count: expected %0d, got %0d", want.faults, got.faults);
        errors++;
      end
    endfunction
  endclass

  // Clock, reset and block inputs, all known from time zero.
  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we_i      = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i   = '0;
  logic             in_valid_i    = 1'b0;
  page_t            page_number_i = '0;
  logic             out_stall_i   = 1'b0;

  logic             in_stall_o;
  logic             out_valid_o;
  logic             hit_o;
  idx_t             frame_index_o;
  logic             evicted_valid_o;
  page_t            evicted_page_o;
  fault_t           fault_count_o;

  frame_table_model ledger = new();

  // Stimulus bookkeeping.
  bit               quiet_sink    = 1'b0;  // no new receiver stall runs while set
  int unsigned      stall_run     = 0;
  int unsigned      requests_sent = 0;
  page_t            script [$];

  lru_frame_replacement uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap length for both sides: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Receiver: hold stall high or low for random runs; while quiet_sink is set,
  // drop it once the current run ends so results drain without back-pressure.
  always @(posedge clk_i) begin
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else if (quiet_sink) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_run   <= pick_gap();
    end
  end

  // Check every result taken by the receiver. Values are sampled at the
  // edge, before the block's own updates for that edge land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      ledger.check_result('{hit_o, frame_index_o, evicted_valid_o, evicted_page_o,
                            fault_count_o});
  end

  // Offer one request, hold it until taken, then idle for the given gap.
  // Valid stays high into the next request when gap is zero.
  task automatic send_page(input page_t pg, input int unsigned gap);
    in_valid_i    <= 1'b1;
    page_number_i <= pg;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(pg);
    requests_sent++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  // Hold the sender until every outstanding request has its result.
  task automatic drain();
    while (ledger.outstanding() != 0) @(posedge clk_i);
  endtask

  // Write the table size; only ever done with the block idle.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_frames(value);
  endtask

  // Play the directed script with random gaps, then drop valid.
  task automatic send_script();
    foreach (script[i]) send_page(script[i], pick_gap());
    drop_valid();
  endtask

  // Hard stop if the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    int unsigned cfg;
    int unsigned n_eff;
    page_t       pool [$];
    page_t       pg;

    // Hold reset low from time zero, then release it at an edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full table: fill all eight frames with extreme and alternating page
    // numbers, hit twice, then force an eviction of the oldest frame.
    write_frames(4'd8);
    script = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
               16'h1234, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4321, 16'h0000};
    send_script();

    // Shrink to two frames: pages outside the window are ignored, so a page
    // still held in frame 6 faults and lands in frame 0 or 1.
    write_frames(4'd2);
    script = '{16'h5555, 16'h1234, 16'h0000};
    send_script();

    // Grow back: the page now sits twice; the lowest frame must hit.
    write_frames(4'd8);
    script = '{16'h1234, 16'h5555};
    send_script();

    // Size zero behaves as one frame, oversize values as the full table.
    write_frames(4'd0);
    script = '{16'h00FF, 16'h00FF, 16'hFF00};
    send_script();
    write_frames(4'd15);
    script = '{16'h00FF, 16'h1234};
    send_script();

    // Random phases: each picks a table size and a working set the size of the
    // table or up to three pages larger, so hits, fills and evictions all recur;
    // one in five requests is a fully random page.
    for (ph = 0; ph < PHASES; ph++) begin
      cfg = (ph < 8) ? SWEEP[ph] : $urandom_range(0, 15);
      write_frames(cfg[CFG_W-1:0]);
      quiet_sink <= (ph == 2 || ph == 6);
      n_eff = (cfg == 0) ? 1 : ((cfg > FRAMES) ? FRAMES : cfg);
      pool.delete();
      repeat (n_eff + $urandom_range(0, 3)) pool.push_back(page_t'($urandom_range(0, 65535)));
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        // Once in the run, let the pipeline empty completely mid-stream.
        if (ph == 4 && k == ITEMS_PER_PHASE / 2) begin
          drop_valid();
          drain();
        end
        if ($urandom_range(0, 9) < 8)
          pg = pool[$urandom_range(0, pool.size() - 1)];
        else
          pg = page_t'($urandom_range(0, 65535));
        send_page(pg, (ph == 2 || ph == 6) ? 0 : pick_gap());
      end
      drop_valid();
    end

    // Wait for the last results, then let the bench settle to catch strays.
    quiet_sink <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests (%0d hits, %0d faults) over table sizes 0 to 15,",
             requests_sent, ledger.hits, ledger.misses);
    $display("including resizes with stale frames, burst phases and a full drain mid-stream.");
    if (ledger.errors == 0 && ledger.outstanding() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lrufr_pkg.sv
hw/rtl/lrufr_store.sv
hw/rtl/lru_frame_replacement.sv
bench/tb.sv
